// ===== sv/cfrtb_pkg.sv =====
// Shared types, codes and helpers for the chunked frame reassembly block.
// No dependencies; every other file of the block imports this package.
package cfrtb_pkg;

   // Fixed geometry of the reassembly scheme.
   localparam int unsigned BUFFER_COUNT = 3;
   localparam int unsigned BUF_IDX_W    = 2;
   localparam int unsigned HDR_BYTES    = 20;
   localparam logic [31:0] MAGIC_RESET  = 32'h4652_4D45;
   localparam logic [31:0] FRAME_NONE   = 32'hFFFF_FFFF;

   // Register file layout: byte address bits and register indexes.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic        REG_MAGIC  = 1'b0;

   // Event kinds on the request channel.
   typedef enum logic [1:0] {
      KIND_CHUNK   = 2'd0,
      KIND_TAKE    = 2'd1,
      KIND_RELEASE = 2'd2
   } kind_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_INVALID   = 3'd0,
      ST_STALE     = 3'd1,
      ST_STORED    = 3'd2,
      ST_PUBLISHED = 3'd3,
      ST_TAKEN     = 3'd4,
      ST_NONE      = 3'd5,
      ST_RELEASED  = 3'd6,
      ST_MISMATCH  = 3'd7
   } status_type;

   // One request beat.
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] packet_len;
      logic [31:0] magic;
      logic [31:0] frame_tag;
      logic [31:0] frame_size;
      logic [31:0] seg_offset;
      logic [31:0] seg_len;
      logic [1:0]  release_buffer;
   } req_item_type;

   // One response beat.
   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  buffer;
      logic [15:0] write_offset;
      logic [16:0] write_length;
      logic [1:0]  published_buffer;
      logic [1:0]  next_rx_buffer;
   } rsp_item_type;

   // Lowest buffer index that is neither published nor in processing.
   function automatic logic [BUF_IDX_W-1:0] pick_free_buffer(
      input logic                 pub_valid,
      input logic [BUF_IDX_W-1:0] pub_idx,
      input logic                 proc_valid,
      input logic [BUF_IDX_W-1:0] proc_idx,
      input logic [BUF_IDX_W-1:0] fallback
   );
      logic [BUF_IDX_W-1:0] pick;
      logic                 found;
      pick  = fallback;
      found = 1'b0;
      for (int i = 0; i < BUFFER_COUNT; i++) begin
         if (!found && !(pub_valid && pub_idx == BUF_IDX_W'(i)) &&
             !(proc_valid && proc_idx == BUF_IDX_W'(i))) begin
            pick  = BUF_IDX_W'(i);
            found = 1'b1;
         end
      end
      return pick;
   endfunction

endpackage

// ===== sv/cfrtb_ifs.sv =====
// Valid/ready channel interfaces for the request and response streams.
// Depends on cfrtb_pkg for the beat payload types.
interface cfrtb_req_if import cfrtb_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cfrtb_rsp_if import cfrtb_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/cfrtb_csr.sv =====
// APB-style register file holding the expected header magic word.
// Depends on cfrtb_pkg for the address layout and reset value.
module cfrtb_csr import cfrtb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output logic [31:0]           magic_word
);

   logic [31:0] magic_ff;
   logic [31:0] magic_in;
   logic        reg_idx;
   logic        wr_en;

   // Word index from the byte address; the low bits select byte lanes only.
   assign reg_idx = paddr[CSR_ADDR_W-1];
   assign wr_en   = psel && penable && pwrite && (reg_idx == REG_MAGIC);
   assign pready  = 1'b1;

   // Write in the access phase.
   always_comb begin
      magic_in = magic_ff;
      if (wr_en) begin
         magic_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= MAGIC_RESET;
      end else begin
         magic_ff <= magic_in;
      end
   end

   // Addresses past the magic register read as zero.
   assign prdata     = (reg_idx == REG_MAGIC) ? magic_ff : 32'd0;
   assign magic_word = magic_ff;

endmodule

// ===== sv/cfrtb_in_reg.sv =====
// Input register stage: captures one request beat and holds it until the
// engine consumes it. Depends on cfrtb_pkg and the request interface.
module cfrtb_in_reg import cfrtb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   cfrtb_req_if.sink    req_chan,
   input  logic         advance,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   // Ready whenever the stage is empty or its beat moves on this cycle.
   assign req_chan.ready = !valid_ff || advance;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload holds without reset.
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_chan.data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== sv/cfrtb_engine.sv =====
// Reassembly engine: header checks, frame tracking, triple-buffer rotation
// and the response register. Depends on cfrtb_pkg and the response interface.
module cfrtb_engine import cfrtb_pkg::*; #(
   parameter int unsigned FRAME_BYTES = 65536
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  req_item_type item,
   input  logic [31:0]  magic_word,
   output logic         advance,
   cfrtb_rsp_if.source  rsp_chan
);

   // Frame and buffer state.
   logic [31:0]          active_ff, active_in;
   logic [31:0]          count_ff, count_in;
   logic                 done_ff, done_in;
   logic [BUF_IDX_W-1:0] rx_ff, rx_in;
   logic [BUF_IDX_W-1:0] pub_ff, pub_in;
   logic                 pub_valid_ff, pub_valid_in;
   logic [BUF_IDX_W-1:0] proc_ff, proc_in;
   logic                 proc_valid_ff, proc_valid_in;

   // Response register.
   logic                 res_valid_ff, res_valid_in;
   rsp_item_type         res_ff, res_in;

   // Header check terms.
   logic [32:0]          bound_sum;
   logic [32:0]          pkt_need;
   logic                 hdr_ok;
   logic                 restart;
   logic [31:0]          active_eff;
   logic [31:0]          count_base;
   logic [31:0]          count_sum;
   logic                 fire;
   status_type           status;

   // The result register frees up when empty or when its beat is taken.
   assign advance = !res_valid_ff || rsp_chan.ready;
   assign fire    = item_valid && advance;

   // Bounds are summed one bit wider so that they cannot wrap.
   assign bound_sum  = {1'b0, item.seg_offset} + {1'b0, item.seg_len};
   assign pkt_need   = 33'(HDR_BYTES) + {1'b0, item.seg_len};
   assign hdr_ok     = (item.packet_len >= 16'(HDR_BYTES)) &&
                       (item.magic == magic_word) &&
                       (item.frame_size == 32'(FRAME_BYTES)) &&
                       (bound_sum <= 33'(FRAME_BYTES)) &&
                       ({17'd0, item.packet_len} >= pkt_need);
   assign restart    = (item.seg_offset == 32'd0);
   assign active_eff = restart ? item.frame_tag : active_ff;
   assign count_base = restart ? 32'd0 : count_ff;
   assign count_sum  = count_base + item.seg_len;

   // Event decode and next state.
   always_comb begin
      active_in     = active_ff;
      count_in      = count_ff;
      done_in       = done_ff;
      rx_in         = rx_ff;
      pub_in        = pub_ff;
      pub_valid_in  = pub_valid_ff;
      proc_in       = proc_ff;
      proc_valid_in = proc_valid_ff;
      status        = ST_INVALID;
      res_in        = '0;

      case (item.kind)
         KIND_CHUNK: begin
            if (hdr_ok) begin
               if (restart) begin
                  active_in = item.frame_tag;
                  count_in  = 32'd0;
                  done_in   = 1'b0;
               end
               if ((item.frame_tag == active_eff) && (restart || !done_ff)) begin
                  res_in.buffer       = rx_ff;
                  res_in.write_offset = item.seg_offset[15:0];
                  res_in.write_length = item.seg_len[16:0];
                  count_in            = count_sum;
                  status              = ST_STORED;
                  if (count_sum == 32'(FRAME_BYTES)) begin
                     pub_in       = rx_ff;
                     pub_valid_in = 1'b1;
                     done_in      = 1'b1;
                     rx_in        = pick_free_buffer(1'b1, rx_ff, proc_valid_ff,
                                                     proc_ff, rx_ff);
                     status       = ST_PUBLISHED;
                  end
               end else begin
                  status = ST_STALE;
               end
            end
         end
         KIND_TAKE: begin
            proc_in       = pub_ff;
            proc_valid_in = pub_valid_ff;
            if (pub_valid_ff) begin
               status        = ST_TAKEN;
               res_in.buffer = pub_ff;
            end else begin
               status = ST_NONE;
            end
         end
         KIND_RELEASE: begin
            if (proc_valid_ff && (proc_ff == item.release_buffer)) begin
               proc_valid_in = 1'b0;
               status        = ST_RELEASED;
            end else begin
               status = ST_MISMATCH;
            end
         end
         default: begin
            status = ST_INVALID;
         end
      endcase

      res_in.status           = status;
      res_in.published_buffer = pub_in;
      res_in.next_rx_buffer   = rx_in;
   end

   // Result valid follows the usual output-register rule.
   always_comb begin
      res_valid_in = res_valid_ff;
      if (fire) begin
         res_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         res_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= FRAME_NONE;
         count_ff      <= 32'd0;
         done_ff       <= 1'b0;
         rx_ff         <= '0;
         pub_ff        <= '0;
         pub_valid_ff  <= 1'b0;
         proc_ff       <= '0;
         proc_valid_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         res_valid_ff <= res_valid_in;
         if (fire) begin
            active_ff     <= active_in;
            count_ff      <= count_in;
            done_ff       <= done_in;
            rx_ff         <= rx_in;
            pub_ff        <= pub_in;
            pub_valid_ff  <= pub_valid_in;
            proc_ff       <= proc_in;
            proc_valid_ff <= proc_valid_in;
         end
      end
   end

   // Response payload needs no reset.
   always_ff @(posedge clock) begin
      if (fire) begin
         res_ff <= res_in;
      end
   end

   assign rsp_chan.valid = res_valid_ff;
   assign rsp_chan.data  = res_ff;

   // The receive buffer never aliases the published frame.
   a_rx_not_published: assert property (@(posedge clock) disable iff (reset)
      !(pub_valid_ff && (rx_ff == pub_ff)))
      else $error("receive buffer equals published buffer");

   // The receive buffer never aliases the frame in processing.
   a_rx_not_processing: assert property (@(posedge clock) disable iff (reset)
      !(proc_valid_ff && (rx_ff == proc_ff)))
      else $error("receive buffer equals processing buffer");

   // A publish leaves the frame closed and a valid published buffer behind.
   a_publish_state: assert property (@(posedge clock) disable iff (reset)
      (fire && (res_in.status == ST_PUBLISHED)) |=> (done_ff && pub_valid_ff))
      else $error("publish did not update frame state");

   // The response beat reports the receive and published buffers the state now holds.
   a_rsp_rx_matches: assert property (@(posedge clock) disable iff (reset)
      fire |=> (res_ff.next_rx_buffer == rx_ff) && (res_ff.published_buffer == pub_ff))
      else $error("response buffer indexes disagree with state");

endmodule

// ===== sv/chunked_frame_reassembly_triple_buffer.sv =====
// Chunked frame reassembly over three rotating buffers. Each request beat is one
// event: a chunk header, a consumer take or a consumer release, and each yields
// exactly one response beat. The block sustains one beat per clock while the
// response side does not stall; a beat is captured in the input register and
// leaves through the response register. A held response stalls the input once
// both registers are full. That rate is set by the update of the frame and
// buffer state, which every event reads and writes. The expected magic word
// sits at byte address 0 of the APB-style register port and may be changed
// while idle.
module chunked_frame_reassembly_triple_buffer import cfrtb_pkg::*; #(
   parameter int unsigned FRAME_BYTES = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   cfrtb_req_if.sink             req_chan,
   cfrtb_rsp_if.source           rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [31:0]  magic_word;
   logic         advance;
   logic         item_valid;
   req_item_type item;

   // Configuration registers.
   cfrtb_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .magic_word (magic_word)
   );

   // Request capture.
   cfrtb_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // Event processing and response register.
   cfrtb_engine #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .magic_word (magic_word),
      .advance    (advance),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the chunked frame reassembly block with three buffers.
// Depends on cfrtb_pkg, the cfrtb channel interfaces and the block's top module.
`timescale 1ns / 1ps

module tb_top;
   import cfrtb_pkg::*;

   localparam int unsigned CLK_PERIOD  = 10;
   localparam int unsigned FRAME_LEN   = 65536;
   localparam int unsigned MAX_PAYLOAD = 65535 - HDR_BYTES;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned LONG_HOLD   = 300;
   localparam logic [1:0]  KIND_UNDEFINED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] MAGIC_ADDR = CSR_ADDR_W'(4 * int'(REG_MAGIC));

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   cfrtb_req_if req_chan ();
   cfrtb_rsp_if rsp_chan ();

   chunked_frame_reassembly_triple_buffer #(
      .FRAME_BYTES(FRAME_LEN)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Mirror of the reassembly state, advanced on every accepted request beat.
   logic [31:0] model_magic;
   logic [31:0] cur_frame;
   logic [31:0] rx_bytes;
   logic        frame_complete;
   logic [1:0]  rx_idx;
   logic [1:0]  pub_idx;
   logic        pub_valid;
   logic [1:0]  proc_idx;
   logic        proc_valid;

   rsp_item_type awaited_outcomes[$];
   int unsigned  failures = 0;

   // Stimulus knobs.
   logic [31:0] magic_setting = MAGIC_RESET;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned beats_sent    = 0;
   logic        hold_toggle;
   int unsigned quiet_cycles  = 0;

   // Computes the response to one event and updates the mirrored state.
   function automatic rsp_item_type reassemble_event(input req_item_type ev);
      rsp_item_type r;
      logic [32:0]  span;
      logic [32:0]  need;
      logic         hdr_ok;
      r        = '0;
      r.status = ST_INVALID;
      case (ev.kind)
         KIND_CHUNK: begin
            // Sums are widened so that a huge offset or length cannot wrap.
            span   = {1'b0, ev.seg_offset} + {1'b0, ev.seg_len};
            need   = 33'(HDR_BYTES) + {1'b0, ev.seg_len};
            hdr_ok = (ev.packet_len >= HDR_BYTES) && (ev.magic == model_magic) &&
                     (ev.frame_size == FRAME_LEN) && (span <= 33'(FRAME_LEN)) &&
                     ({17'b0, ev.packet_len} >= need);
            if (hdr_ok) begin
               if (ev.seg_offset == 32'd0) begin
                  cur_frame      = ev.frame_tag;
                  rx_bytes       = 32'd0;
                  frame_complete = 1'b0;
               end
               if (ev.frame_tag == cur_frame && !frame_complete) begin
                  r.buffer       = rx_idx;
                  r.write_offset = ev.seg_offset[15:0];
                  r.write_length = ev.seg_len[16:0];
                  rx_bytes       = rx_bytes + ev.seg_len;
                  r.status       = ST_STORED;
                  if (rx_bytes == FRAME_LEN) begin
                     pub_idx        = rx_idx;
                     pub_valid      = 1'b1;
                     frame_complete = 1'b1;
                     r.status       = ST_PUBLISHED;
                     // Scan downward so the lowest idle buffer wins.
                     for (int b = BUFFER_COUNT - 1; b >= 0; b--) begin
                        if (!(pub_valid && pub_idx == 2'(b)) &&
                            !(proc_valid && proc_idx == 2'(b)))
                           rx_idx = 2'(b);
                     end
                  end
               end else begin
                  r.status = ST_STALE;
               end
            end
         end
         KIND_TAKE: begin
            proc_idx   = pub_idx;
            proc_valid = pub_valid;
            if (pub_valid) begin
               r.status = ST_TAKEN;
               r.buffer = pub_idx;
            end else begin
               r.status = ST_NONE;
            end
         end
         KIND_RELEASE: begin
            if (proc_valid && proc_idx == ev.release_buffer) begin
               proc_valid = 1'b0;
               r.status   = ST_RELEASED;
            end else begin
               r.status = ST_MISMATCH;
            end
         end
         default: r.status = ST_INVALID;
      endcase
      r.published_buffer = pub_idx;
      r.next_rx_buffer   = rx_idx;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input rsp_item_type want,
                                  input rsp_item_type got);
      failures++;
      if (failures <= 10)
         $display("%0t: %s: status %0d/%0d buffer %0d/%0d offset %0d/%0d length %0d/%0d %s",
                  $realtime, what, want.status, got.status, want.buffer, got.buffer,
                  want.write_offset, got.write_offset, want.write_length,
                  got.write_length,
                  $sformatf("published %0d/%0d rx %0d/%0d (expected/actual)",
                            want.published_buffer, got.published_buffer,
                            want.next_rx_buffer, got.next_rx_buffer));
   endtask

   // Observes both channels and the register port at every rising edge.
   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      if (reset) begin
         model_magic    = MAGIC_RESET;
         cur_frame      = FRAME_NONE;
         rx_bytes       = 32'd0;
         frame_complete = 1'b0;
         rx_idx         = 2'd0;
         pub_idx        = 2'd0;
         pub_valid      = 1'b0;
         proc_idx       = 2'd0;
         proc_valid     = 1'b0;
         awaited_outcomes.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == MAGIC_ADDR)
            model_magic = pwdata;
         if (req_chan.valid && req_chan.ready)
            awaited_outcomes.push_back(reassemble_event(req_chan.data));
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.data;
            if (awaited_outcomes.size() == 0) begin
               report_mismatch("response beat with nothing awaited", '0, got);
            end else begin
               want = awaited_outcomes.pop_front();
               if (got.status !== want.status || got.buffer !== want.buffer ||
                   got.write_offset !== want.write_offset ||
                   got.write_length !== want.write_length ||
                   got.published_buffer !== want.published_buffer ||
                   got.next_rx_buffer !== want.next_rx_buffer)
                  report_mismatch("response beat mismatch", want, got);
            end
         end
      end
   end

   // Response side: random back-pressure, plus one long hold on request.
   always @(posedge clock) begin
      logic        seen_toggle;
      int unsigned hold_left;
      if (reset) begin
         seen_toggle = hold_toggle;
         hold_left   = 0;
         rsp_chan.ready <= 1'b0;
      end else if (hold_toggle != seen_toggle) begin
         seen_toggle = hold_toggle;
         hold_left   = LONG_HOLD;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Ends the run when no beat moves for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready) || (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("chunked_frame_reassembly_triple_buffer verification failed");
         $finish;
      end
   end

   // Offers one request beat, with random gaps first, and waits until it is taken.
   task automatic send_beat(input req_item_type ev, input bit counts);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= ev;
      do @(posedge clock); while (!req_chan.ready);
      if (counts)
         beats_sent++;
   endtask

   // Well-formed chunk header; the packet carries a little random slack.
   function automatic req_item_type chunk_beat(input logic [31:0] fid,
                                               input logic [31:0] off,
                                               input logic [31:0] len);
      req_item_type ev;
      longint unsigned plen;
      ev   = '0;
      plen = longint'(HDR_BYTES) + len + $urandom_range(0, 3) * $urandom_range(0, 60);
      if (plen > 65535)
         plen = 65535;
      ev.kind           = KIND_CHUNK;
      ev.packet_len     = 16'(plen);
      ev.magic          = magic_setting;
      ev.frame_tag      = fid;
      ev.frame_size     = FRAME_LEN;
      ev.seg_offset     = off;
      ev.seg_len        = len;
      ev.release_buffer = 2'($urandom_range(0, 3));
      return ev;
   endfunction

   // Fully random beat; half of them carry a correct magic and frame size.
   function automatic req_item_type noise_beat();
      req_item_type ev;
      ev.kind           = 2'($urandom);
      ev.packet_len     = 16'($urandom);
      ev.magic          = $urandom;
      ev.frame_tag      = $urandom;
      ev.frame_size     = $urandom;
      ev.seg_offset     = $urandom;
      ev.seg_len        = $urandom;
      ev.release_buffer = 2'($urandom);
      if ($urandom_range(0, 1) == 1) begin
         ev.magic      = magic_setting;
         ev.frame_size = FRAME_LEN;
      end
      return ev;
   endfunction

   function automatic req_item_type take_beat();
      req_item_type ev;
      ev      = noise_beat();
      ev.kind = KIND_TAKE;
      return ev;
   endfunction

   // Release of a given buffer; other fields carry junk the block must ignore.
   function automatic req_item_type release_beat(input logic [1:0] idx);
      req_item_type ev;
      ev                = noise_beat();
      ev.kind           = KIND_RELEASE;
      ev.release_buffer = idx;
      return ev;
   endfunction

   // Mostly returns the buffer in processing, sometimes any index.
   function automatic logic [1:0] release_guess();
      if ($urandom_range(0, 4) == 0)
         return 2'($urandom_range(0, 3));
      return proc_idx;
   endfunction

   // Stops sending and lets every awaited response drain.
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (awaited_outcomes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes the magic register while idle and reads it back.
   task automatic program_magic(input logic [31:0] value);
      logic [31:0] readback;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= MAGIC_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      magic_setting = value;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback !== value) begin
         failures++;
         if (failures <= 10)
            $display("%0t: magic readback %h, expected %h", $realtime, readback, value);
      end
   endtask

   // Occasional consumer events, noise and stale chunks between frame chunks.
   task automatic side_traffic();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 6)
         send_beat(take_beat(), 1'b1);
      else if (pick < 10)
         send_beat(release_beat(release_guess()), 1'b1);
      else if (pick < 14)
         send_beat(noise_beat(), 1'b0);
      else if (pick < 16)
         send_beat(chunk_beat($urandom, $urandom_range(1, 1000), $urandom_range(0, 500)),
                   1'b1);
   endtask

   // One frame cut into random chunks; offset zero leads, the rest may be shuffled.
   // A chunk is sometimes dropped or repeated, which can keep the frame unpublished.
   task automatic send_frame();
      logic [31:0] fid;
      int unsigned cuts[$];
      int unsigned order[$];
      int unsigned pieces;
      int unsigned k;
      bit          fits;
      fid    = ($urandom_range(0, 19) == 0) ? FRAME_NONE : $urandom;
      pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(2, 5);
      do begin
         cuts.delete();
         cuts.push_back(0);
         cuts.push_back(FRAME_LEN);
         for (k = 1; k < pieces; k++)
            cuts.push_back($urandom_range(0, FRAME_LEN));
         cuts.sort();
         fits = 1'b1;
         for (k = 1; k < cuts.size(); k++)
            if (cuts[k] - cuts[k-1] > MAX_PAYLOAD)
               fits = 1'b0;
      end while (!fits);
      order.delete();
      for (k = 1; k < pieces; k++)
         order.push_back(k);
      if ($urandom_range(0, 2) == 0)
         order.shuffle();
      order.push_front(0);
      foreach (order[i]) begin
         k = order[i];
         if (i != 0 && $urandom_range(0, 39) == 0)
            continue;
         send_beat(chunk_beat(fid, cuts[k], cuts[k+1] - cuts[k]), 1'b1);
         if ($urandom_range(0, 49) == 0)
            send_beat(chunk_beat(fid, cuts[k], cuts[k+1] - cuts[k]), 1'b1);
         side_traffic();
      end
      // The consumer usually picks up the frame and often hands a buffer back.
      if ($urandom_range(0, 9) < 6)
         send_beat(take_beat(), 1'b1);
      if ($urandom_range(0, 9) < 5)
         send_beat(release_beat(release_guess()), 1'b1);
   endtask

   // Consumer events before anything is published, and the all-ones frame id.
   task automatic test_reset_state();
      send_beat(take_beat(), 1'b1);
      send_beat(release_beat(2'd0), 1'b1);
      send_beat(release_beat(2'd3), 1'b1);
      // Matches the reset frame id, so it is stored without an offset-zero chunk.
      send_beat(chunk_beat(FRAME_NONE, 32'd100, 32'd10), 1'b1);
   endtask

   // Each header check on its own, plus the undefined event kind.
   task automatic test_header_checks();
      req_item_type ev;
      ev = chunk_beat(32'd5, 32'd0, 32'd0);
      ev.packet_len = 16'(HDR_BYTES - 1);
      send_beat(ev, 1'b1);
      ev = chunk_beat(32'd5, 32'd0, 32'd8);
      ev.magic = ~magic_setting;
      send_beat(ev, 1'b1);
      ev = chunk_beat(32'd5, 32'd0, 32'd8);
      ev.frame_size = FRAME_LEN - 1;
      send_beat(ev, 1'b1);
      ev.frame_size = 32'hFFFF_FFFF;
      send_beat(ev, 1'b1);
      // Offset plus length must not wrap past 32 bits.
      send_beat(chunk_beat(32'd5, 32'hFFFF_FFFF, 32'd1), 1'b1);
      // Header plus a huge length must not wrap either.
      send_beat(chunk_beat(32'd5, 32'd0, 32'hFFFF_FFFF), 1'b1);
      ev = chunk_beat(32'd5, 32'd0, 32'd100);
      ev.packet_len = 16'(HDR_BYTES + 99);
      send_beat(ev, 1'b1);
      // Ends exactly at the frame size: valid, but not the active frame.
      send_beat(chunk_beat(32'd5, FRAME_LEN, 32'd0), 1'b1);
      ev = chunk_beat(32'd5, 32'd0, 32'd8);
      ev.kind = KIND_UNDEFINED;
      send_beat(ev, 1'b1);
   endtask

   // Two frames published back to back with take and release around them.
   task automatic test_publish_and_consume();
      req_item_type ev;
      ev = chunk_beat(32'd0, 32'd0, 32'd0);
      ev.packet_len = 16'(HDR_BYTES);
      send_beat(ev, 1'b1);
      ev = chunk_beat(32'd0, 32'd0, MAX_PAYLOAD);
      ev.packet_len = 16'hFFFF;
      send_beat(ev, 1'b1);
      send_beat(chunk_beat(32'd0, MAX_PAYLOAD, FRAME_LEN - MAX_PAYLOAD), 1'b1);
      // The frame is already published, so more of it is stale.
      send_beat(chunk_beat(32'd0, 32'd100, 32'd10), 1'b1);
      send_beat(take_beat(), 1'b1);
      send_beat(chunk_beat(32'hFFFF_FFFE, 32'd0, MAX_PAYLOAD), 1'b1);
      send_beat(chunk_beat(32'hFFFF_FFFE, MAX_PAYLOAD, FRAME_LEN - MAX_PAYLOAD), 1'b1);
      send_beat(release_beat(2'd2), 1'b1);
      send_beat(release_beat(2'd0), 1'b1);
      send_beat(take_beat(), 1'b1);
   endtask

   // Overlapping chunks push the byte count past the frame size.
   task automatic test_overcount();
      send_beat(chunk_beat(32'd9, 32'd0, 32'd40000), 1'b1);
      send_beat(chunk_beat(32'd9, 32'd30000, 32'd35536), 1'b1);
   endtask

   // Random frames under one magic setting and one idle pattern.
   task automatic test_random_traffic(input logic [31:0] magic, input int unsigned target,
                                      input int unsigned send_pct,
                                      input int unsigned recv_pct, input bit with_hold);
      bit held;
      held = 1'b0;
      program_magic(magic);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      beats_sent    = 0;
      while (beats_sent < target) begin
         if (with_hold && !held && beats_sent >= target / 3) begin
            // Long response hold while requests keep coming.
            hold_toggle <= ~hold_toggle;
            held = 1'b1;
         end
         send_frame();
      end
      settle();
   endtask

   initial begin
      reset          <= 1'b1;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      req_chan.valid <= 1'b0;
      req_chan.data  <= '0;
      hold_toggle    <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 8;
      recv_idle_pct = 54;
      test_reset_state();
      test_header_checks();
      test_publish_and_consume();
      test_overcount();
      settle();

      test_random_traffic(32'h0000_0000, 350, 8, 54, 1'b0);
      test_random_traffic(32'hFFFF_FFFF, 350, 54, 8, 1'b0);
      test_random_traffic($urandom, 350, 0, 0, 1'b1);

      if (awaited_outcomes.size() != 0)
         failures += awaited_outcomes.size();
      if (failures == 0)
         $display("chunked_frame_reassembly_triple_buffer verification clean");
      else
         $display("chunked_frame_reassembly_triple_buffer verification failed");
      $finish;
   end

endmodule
